// File: rtl/alst_pkg.sv
// Package for the array list engine: sizes, operation and status codes,
// sentinels and the result record shared by the sequencer and the top level.
// No dependencies.
`default_nettype none

package alst_pkg;

  // List geometry
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Item field widths
  localparam int FUNC_W   = 4;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;

  // Stream bus widths (whole bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  // Running extremes start from these values
  localparam logic signed [DATA_W-1:0] MAX_SENTINEL = -32'sd9999999;
  localparam logic signed [DATA_W-1:0] MIN_SENTINEL = 32'sd9999999;

  // Operation selector
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 4'd0,
    FN_INS_AT   = 4'd1,
    FN_INS_TAIL = 4'd2,
    FN_RM_HEAD  = 4'd3,
    FN_RM_AT    = 4'd4,
    FN_RM_TAIL  = 4'd5,
    FN_CONTAINS = 4'd6,
    FN_READ     = 4'd7,
    FN_EVENS    = 4'd8,
    FN_MAX      = 4'd9,
    FN_MIN      = 4'd10,
    FN_POSMAX   = 4'd11,
    FN_POSMIN   = 4'd12,
    FN_SUM      = 4'd13,
    FN_MEAN     = 4'd14
  } func_e;

  // Result status
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // One result item as handed from the sequencer to the output register
  typedef struct packed {
    status_e              status;
    logic [DATA_W-1:0]    data;
    logic [COUNT_W-1:0]   count;
    logic                 full;
    logic                 empty;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/alst_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module alst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/alst_div.sv
// Iterative signed divider for the mean: 32-bit dividend by the fill count,
// one quotient bit per cycle, truncating toward zero. Depends on alst_pkg.
`default_nettype none

module alst_div
  import alst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;
  logic [DATA_W-1:0] dvd_q, dvd_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W:0]    rem_sh;
  logic              qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[CNT_W-1:0], dvd_q[DATA_W-1]};
    qbit   = (rem_sh >= {1'b0, dsr_q});
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = dividend_i[DATA_W-1];
      dvd_d  = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = qbit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      dvd_d  = {dvd_q[DATA_W-2:0], qbit};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  // Restore the sign of the quotient
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~dvd_q + 1'b1) : dvd_q;

endmodule

`default_nettype wire

// File: rtl/alst_seq.sv
// Operation sequencer: decodes an item, walks the entry memory one address
// per cycle (shift up, shift down or scan) and builds the result.
// Depends on alst_pkg, alst_ram and alst_div.
`default_nettype none

module alst_seq
  import alst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [FUNC_W-1:0]         op_q, op_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [DATA_W-1:0]         val_q, val_d;
  logic [IDX_W-1:0]          rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]          rd_left_q, rd_left_d;
  logic                      rd_down_q, rd_down_d;
  logic                      rv_q, rv_d;
  logic [IDX_W-1:0]          ra_q, ra_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [DATA_W-1:0]         acc_q, acc_d;
  logic signed [DATA_W-1:0]  best_q, best_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic                      found_q, found_d;
  status_e                   status_q, status_d;
  logic [DATA_W-1:0]         data_q, data_d;

  logic                      list_full, list_empty, pos_bad;
  logic [IDX_W-1:0]          sel_idx;
  logic                      mem_we, mem_re;
  logic [IDX_W-1:0]          mem_waddr;
  logic [DATA_W-1:0]         mem_wdata, mem_rdata;
  logic                      div_start, div_done;
  logic [DATA_W-1:0]         div_quot;

  alst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  alst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // List condition checks on the current fill count
  assign list_full  = (cnt_q == CNT_W'(CAPACITY));
  assign list_empty = (cnt_q == '0);
  assign pos_bad    = (int'(position_i) >= int'(cnt_q));
  assign mem_re     = (state_q == S_RUN) && (rd_left_q != '0);
  assign in_ready_o = (state_q == S_IDLE);

  // Index that an operation starts from
  always_comb begin
    unique case (func_e'(func_i))
      FN_INS_AT, FN_RM_AT, FN_READ: sel_idx = IDX_W'(position_i);
      FN_INS_TAIL:                  sel_idx = IDX_W'(cnt_q);
      FN_RM_TAIL:                   sel_idx = IDX_W'(cnt_q - 1'b1);
      default:                      sel_idx = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    idx_d     = idx_q;
    val_d     = val_q;
    rd_addr_d = rd_addr_q;
    rd_left_d = rd_left_q;
    rd_down_d = rd_down_q;
    rv_d      = rv_q;
    ra_d      = ra_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    best_d    = best_q;
    pos_d     = pos_q;
    found_d   = found_q;
    status_d  = status_q;
    data_d    = data_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = val_q;
    div_start = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = func_i;
          val_d     = value_i;
          idx_d     = sel_idx;
          status_d  = ST_OK;
          data_d    = '0;
          acc_d     = '0;
          found_d   = 1'b0;
          pos_d     = '0;
          best_d    = (func_i == FN_MIN || func_i == FN_POSMIN) ? MIN_SENTINEL
                                                                 : MAX_SENTINEL;
          rv_d      = 1'b0;
          rd_down_d = 1'b0;
          rd_addr_d = '0;
          rd_left_d = cnt_q;
          state_d   = S_RUN;
          unique case (func_e'(func_i))
            FN_INS_HEAD, FN_INS_AT, FN_INS_TAIL: begin
              // Shift up from the tail down to the insert index
              rd_down_d = 1'b1;
              rd_addr_d = IDX_W'(cnt_q - 1'b1);
              rd_left_d = cnt_q - CNT_W'(sel_idx);
              if (list_full) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else if (func_i == FN_INS_AT && pos_bad) begin
                status_d = ST_BADPOS;
                state_d  = S_DONE;
              end
            end
            FN_RM_HEAD, FN_RM_AT, FN_RM_TAIL: begin
              // Read the victim, then pull the rest down by one
              rd_addr_d = sel_idx;
              rd_left_d = cnt_q - CNT_W'(sel_idx);
              if (list_empty) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (func_i == FN_RM_AT && pos_bad) begin
                status_d = ST_BADPOS;
                state_d  = S_DONE;
              end
            end
            FN_READ: begin
              rd_addr_d = sel_idx;
              rd_left_d = CNT_W'(1);
              if (pos_bad) begin
                status_d = ST_BADPOS;
                state_d  = S_DONE;
              end
            end
            FN_MEAN: begin
              if (list_empty) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end
            end
            FN_CONTAINS, FN_EVENS, FN_MAX, FN_MIN, FN_POSMAX, FN_POSMIN,
            FN_SUM: begin
              // Full scan from index zero
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_RUN: begin
        // Issue the next read
        if (rd_left_q != '0) begin
          rd_left_d = rd_left_q - 1'b1;
          rd_addr_d = rd_down_q ? (rd_addr_q - 1'b1) : (rd_addr_q + 1'b1);
          rv_d      = 1'b1;
          ra_d      = rd_addr_q;
        end else begin
          rv_d      = 1'b0;
        end

        // Consume the word that arrived from the previous read
        if (rv_q) begin
          unique case (func_e'(op_q))
            FN_INS_HEAD, FN_INS_AT, FN_INS_TAIL: begin
              mem_we    = 1'b1;
              mem_waddr = ra_q + 1'b1;
              mem_wdata = mem_rdata;
            end
            FN_RM_HEAD, FN_RM_AT, FN_RM_TAIL: begin
              if (ra_q == idx_q) begin
                acc_d = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ra_q - 1'b1;
                mem_wdata = mem_rdata;
              end
            end
            FN_READ: begin
              acc_d = mem_rdata;
            end
            FN_CONTAINS: begin
              if (mem_rdata == val_q) begin
                acc_d = DATA_W'(1);
              end
            end
            FN_EVENS: begin
              if (!mem_rdata[0]) begin
                acc_d = acc_q + 1'b1;
              end
            end
            FN_MAX, FN_POSMAX: begin
              if ($signed(mem_rdata) > best_q) begin
                best_d  = $signed(mem_rdata);
                pos_d   = ra_q;
                found_d = 1'b1;
              end
            end
            FN_MIN, FN_POSMIN: begin
              if ($signed(mem_rdata) < best_q) begin
                best_d  = $signed(mem_rdata);
                pos_d   = ra_q;
                found_d = 1'b1;
              end
            end
            FN_SUM, FN_MEAN: begin
              acc_d = acc_q + mem_rdata;
            end
            default: begin
            end
          endcase
        end

        // Walk finished: commit and form the answer
        if (rd_left_q == '0 && !rv_q) begin
          state_d = S_DONE;
          unique case (func_e'(op_q))
            FN_INS_HEAD, FN_INS_AT, FN_INS_TAIL: begin
              mem_we    = 1'b1;
              mem_waddr = idx_q;
              mem_wdata = val_q;
              cnt_d     = cnt_q + 1'b1;
              data_d    = '0;
            end
            FN_RM_HEAD, FN_RM_AT, FN_RM_TAIL: begin
              cnt_d  = cnt_q - 1'b1;
              data_d = acc_q;
            end
            FN_MAX, FN_MIN: begin
              data_d = best_q;
            end
            FN_POSMAX, FN_POSMIN: begin
              data_d = found_q ? DATA_W'(pos_q) : '1;
            end
            FN_MEAN: begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            default: begin
              data_d = acc_q;
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          data_d  = div_quot;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // Hand over once the output register can take it
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rv_q      <= 1'b0;
      rd_left_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      rv_q      <= rv_d;
      rd_left_q <= rd_left_d;
      cnt_q     <= cnt_d;
    end
  end

  // Operation payload
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    rd_addr_q <= rd_addr_d;
    rd_down_q <= rd_down_d;
    ra_q      <= ra_d;
    acc_q     <= acc_d;
    best_q    <= best_d;
    pos_q     <= pos_d;
    found_q   <= found_d;
    status_q  <= status_d;
    data_q    <= data_d;
  end

  // Result item
  assign res_o.status = status_q;
  assign res_o.data   = data_q;
  assign res_o.count  = COUNT_W'(cnt_q);
  assign res_o.full   = list_full;
  assign res_o.empty  = list_empty;

endmodule

`default_nettype wire

// File: rtl/array_list_engine_top.sv
// Top level of the array list engine: stream ports, output register and
// checks. Depends on alst_pkg and alst_seq.
//
//   Channel   Dir  Group     Carries
//   s_axis    in   tuser     func
//                  tdata     position, value
//   m_axis    out  tuser     status
//                  tdata     data, count, full_res, empty_res
//
// An item walks the entry memory one address per cycle through its single
// read port; the entries walked are the count for scans, count - index for
// shifts and 1 for a read, up to 64. The mean then runs the bit-serial
// divider on the sum.
// Reset empties the list at once; entries are not cleared.
// A stalled result sits in the output register while the next item is taken.
`default_nettype none

module array_list_engine_top
  import alst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // [5:0] position, [37:6] value
  input  logic [FUNC_W-1:0]    s_axis_tuser_i,  // [3:0] func
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [31:0] data, [38:32] count, [39] full_res, [40] empty_res
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [STAT_W-1:0]    m_axis_tuser_o   // [1:0] status
);

  logic out_valid_q, out_valid_d;
  res_t out_res_q, out_res_d;
  logic out_free;
  logic res_valid;
  res_t res;

  assign out_free = !out_valid_q || m_axis_tready_i;

  alst_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .func_i      (s_axis_tuser_i),
    .position_i  (s_axis_tdata_i[POS_W-1:0]),
    .value_i     (s_axis_tdata_i[POS_W+DATA_W-1:POS_W]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load a new result or drop the one just taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  // Pack the result item
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {{(M_TDATA_W - DATA_W - COUNT_W - 2){1'b0}},
                            out_res_q.empty, out_res_q.full,
                            out_res_q.count, out_res_q.data};

  // One item at a time: accepting an item closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while an item is still in work");

  // The fill count never passes capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (int'(out_res_q.count) <= CAPACITY))
    else $error("fill count beyond capacity");

  // Full and empty flags exclude each other
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(out_res_q.full && out_res_q.empty))
    else $error("list flagged full and empty at once");

  // A full-list error is only reported on a full list
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == ST_FULL) |-> out_res_q.full)
    else $error("full status on a list that is not full");

endmodule

`default_nettype wire
